### rtl/core/gwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared constants, types and helpers for the grid wavefront distance map.
// ----------------------------------------------------------------------------
package gwd_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int CELL_COUNT = 1 << ADDR_W;
	localparam int PTR_W      = ADDR_W + 1;
	localparam int DIST_W     = 8;
	localparam int PADDR_W    = 4;

	localparam logic [DIST_W-1:0] DIST_UNKNOWN = 8'hFF;
	localparam logic [DIST_W-1:0] DIST_CAP     = 8'd127;

	localparam logic [1:0] MODE_CLEAR = 2'd0;
	localparam logic [1:0] MODE_SEED  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
	localparam logic [1:0] REG_NEAR_THRESH = 2'd2;

	// Neighbor scan runs nine positions, column offset outer, row offset inner
	localparam logic [3:0] NB_LAST = 4'd9;

	typedef struct packed {
		logic [COL_W:0]      width_use;
		logic [ROW_W:0]      height_use;
		logic [DIST_W-1:0]   threshold;
	} cfg_t;

	typedef struct packed {
		logic              clear_ptr;
		logic              push;
		logic [ADDR_W-1:0] push_addr;
		logic              pop;
	} q_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	// Step codes: 0 is minus one, 1 is zero, 2 is plus one
	typedef struct packed {
		logic [1:0] col_step;
		logic [1:0] row_step;
	} nb_step_t;

	function automatic nb_step_t nb_step(input logic [3:0] k);
		nb_step_t s;
		case (k)
			4'd0:    s = '{col_step: 2'd0, row_step: 2'd0};
			4'd1:    s = '{col_step: 2'd0, row_step: 2'd1};
			4'd2:    s = '{col_step: 2'd0, row_step: 2'd2};
			4'd3:    s = '{col_step: 2'd1, row_step: 2'd0};
			4'd4:    s = '{col_step: 2'd1, row_step: 2'd1};
			4'd5:    s = '{col_step: 2'd1, row_step: 2'd2};
			4'd6:    s = '{col_step: 2'd2, row_step: 2'd0};
			4'd7:    s = '{col_step: 2'd2, row_step: 2'd1};
			4'd8:    s = '{col_step: 2'd2, row_step: 2'd2};
			default: s = '{col_step: 2'd1, row_step: 2'd1};
		endcase
		return s;
	endfunction

endpackage

### rtl/core/grid_wavefront_distance_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map
// 8-connected distance map to obstacle cells with breadth-first seeding.
// ----------------------------------------------------------------------------
// Operation: a read passes through the read and reply states to result_valid;
//   clear writes every cell unknown; seed does, per visited cell, a queue pop,
//   parent fetch and nine neighbor checks through the one grid read port.
// Throughput: one transaction at a time, busy is high until it completes.
// Reset: a clearing pass sets every cell unknown, busy held high.
// result_valid pulses for one cycle; the receiver cannot stall.
module grid_wavefront_distance_map (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gwd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	input  logic [1:0]                  mode,
	input  logic [6:0]                  cell_x,
	input  logic [6:0]                  cell_y,
	output logic                        busy,
	output logic                        result_valid,
	output logic signed [7:0]           distance,
	output logic                        known,
	output logic                        occupied
);
	import gwd_pkg::*;

	cfg_t              cfg;
	q_ctrl_t           q_ctrl;
	q_stat_t           q_stat;
	logic [ADDR_W-1:0] q_rdata;

	gwd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gwd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (q_ctrl),
		.stat   (q_stat),
		.rdata  (q_rdata)
	);

	gwd_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.start        (start),
		.mode         (mode),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.busy         (busy),
		.result_valid (result_valid),
		.distance     (distance),
		.known        (known),
		.occupied     (occupied),
		.q_ctrl       (q_ctrl),
		.q_stat       (q_stat),
		.q_rdata      (q_rdata)
	);

endmodule

### rtl/core/gwd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_cfg_regs
// APB register file: grid width, grid height and near threshold.
// ----------------------------------------------------------------------------
module gwd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [gwd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output gwd_pkg::cfg_t               cfg
);
	import gwd_pkg::*;

	logic [7:0] grid_width_q;
	logic [7:0] grid_height_q;
	logic [7:0] near_thresh_q;
	logic [1:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= 8'd64;
			grid_height_q <= 8'd64;
			near_thresh_q <= 8'd10;
		end else if (wr_en) begin
			case (reg_idx)
				REG_GRID_WIDTH:  grid_width_q  <= pwdata[7:0];
				REG_GRID_HEIGHT: grid_height_q <= pwdata[7:0];
				REG_NEAR_THRESH: near_thresh_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GRID_WIDTH:  prdata = {24'd0, grid_width_q};
			REG_GRID_HEIGHT: prdata = {24'd0, grid_height_q};
			REG_NEAR_THRESH: prdata = {24'd0, near_thresh_q};
			default:         prdata = 32'd0;
		endcase
	end

	// Clamp the grid in use to the stored array size
	always_comb begin
		cfg.width_use  = ({1'b0, grid_width_q} < 9'(MAX_WIDTH)) ?
			(COL_W+1)'(grid_width_q) : (COL_W+1)'(MAX_WIDTH);
		cfg.height_use = ({1'b0, grid_height_q} < 9'(MAX_HEIGHT)) ?
			(ROW_W+1)'(grid_height_q) : (ROW_W+1)'(MAX_HEIGHT);
		cfg.threshold  = near_thresh_q;
	end

endmodule

### rtl/core/gwd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_queue
// Wavefront cell queue: one memory, head and tail pointers, registered read.
// ----------------------------------------------------------------------------
module gwd_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gwd_pkg::q_ctrl_t           ctrl,
	output gwd_pkg::q_stat_t           stat,
	output logic [gwd_pkg::ADDR_W-1:0] rdata
);
	import gwd_pkg::*;

	logic [ADDR_W-1:0] q_mem [CELL_COUNT];
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [PTR_W-1:0]  fill;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] rdata_q;

	assign fill       = tail_q - head_q;
	assign stat.empty = (head_q == tail_q);
	assign stat.full  = fill[PTR_W-1];
	assign waddr      = ctrl.clear_ptr ? '0 : tail_q[ADDR_W-1:0];
	assign rdata      = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else if (ctrl.clear_ptr) begin
			head_q <= '0;
			tail_q <= ctrl.push ? PTR_W'(1) : '0;
		end else begin
			if (ctrl.pop)
				head_q <= head_q + PTR_W'(1);
			if (ctrl.push)
				tail_q <= tail_q + PTR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push)
			q_mem[waddr] <= ctrl.push_addr;
		if (ctrl.pop)
			rdata_q <= q_mem[head_q[ADDR_W-1:0]];
	end

endmodule

### rtl/core/gwd_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwd_engine
// Distance grid memory and the sequencer for clear, seed wavefront and read.
// ----------------------------------------------------------------------------
module gwd_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gwd_pkg::cfg_t              cfg,
	input  logic                       start,
	input  logic [1:0]                 mode,
	input  logic [6:0]                 cell_x,
	input  logic [6:0]                 cell_y,
	output logic                       busy,
	output logic                       result_valid,
	output logic signed [7:0]          distance,
	output logic                       known,
	output logic                       occupied,
	output gwd_pkg::q_ctrl_t           q_ctrl,
	input  gwd_pkg::q_stat_t           q_stat,
	input  logic [gwd_pkg::ADDR_W-1:0] q_rdata
);
	import gwd_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SEED,
		ST_POP,
		ST_FETCH,
		ST_PARENT,
		ST_SCAN,
		ST_READ,
		ST_REPLY
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] cell_addr_q;
	logic              inside_q;
	logic [ADDR_W-1:0] cur_addr_q;
	logic [DIST_W-1:0] next_dist_q;
	logic [3:0]        nb_cnt_q;
	logic              chk_vld_s1;
	logic [ADDR_W-1:0] chk_addr_s1;
	logic              result_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic              known_q;
	logic              occupied_q;

	logic [DIST_W-1:0] grid_mem [CELL_COUNT];
	logic [DIST_W-1:0] grid_rdata_q;
	logic              grid_we;
	logic [ADDR_W-1:0] grid_waddr;
	logic [DIST_W-1:0] grid_wdata;
	logic              grid_re;
	logic [ADDR_W-1:0] grid_raddr;

	logic              accept;
	logic              in_inside;
	logic [ADDR_W-1:0] in_addr;
	nb_step_t          step;
	logic [COL_W:0]    nb_col;
	logic [ROW_W:0]    nb_row;
	logic              nb_inbound;
	logic [ADDR_W-1:0] nb_addr;
	logic              lower;
	logic [DIST_W-1:0] reply_dist;

	assign busy         = (state_q != ST_IDLE);
	assign accept       = start & ~busy;
	assign in_inside    = ({1'b0, cell_x} < 8'(cfg.width_use)) &&
	                      ({1'b0, cell_y} < 8'(cfg.height_use));
	assign in_addr      = {cell_y[ROW_W-1:0], cell_x[COL_W-1:0]};

	assign result_valid = result_valid_q;
	assign distance     = signed'(distance_q);
	assign known        = known_q;
	assign occupied     = occupied_q;

	// Neighbor address; a step below column or row zero wraps to all ones,
	// which always lies beyond the grid in use
	assign step   = nb_step(nb_cnt_q);
	assign nb_col = {1'b0, cur_addr_q[COL_W-1:0]} + (COL_W+1)'(step.col_step) -
	                (COL_W+1)'(1);
	assign nb_row = {1'b0, cur_addr_q[ADDR_W-1:COL_W]} + (ROW_W+1)'(step.row_step) -
	                (ROW_W+1)'(1);
	assign nb_inbound = (nb_col < cfg.width_use) && (nb_row < cfg.height_use);
	assign nb_addr    = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};

	assign lower = chk_vld_s1 &&
	               ((grid_rdata_q == DIST_UNKNOWN) || (grid_rdata_q > next_dist_q));

	assign reply_dist = inside_q ? grid_rdata_q : DIST_UNKNOWN;

	// Memory and queue port control
	always_comb begin
		grid_we          = 1'b0;
		grid_waddr       = chk_addr_s1;
		grid_wdata       = next_dist_q;
		grid_re          = 1'b0;
		grid_raddr       = nb_addr;
		q_ctrl.clear_ptr = 1'b0;
		q_ctrl.push      = 1'b0;
		q_ctrl.push_addr = chk_addr_s1;
		q_ctrl.pop       = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				grid_we    = 1'b1;
				grid_waddr = clr_addr_q;
				grid_wdata = DIST_UNKNOWN;
			end
			ST_SEED: begin
				grid_we          = 1'b1;
				grid_waddr       = cell_addr_q;
				grid_wdata       = '0;
				q_ctrl.clear_ptr = 1'b1;
				q_ctrl.push      = 1'b1;
				q_ctrl.push_addr = cell_addr_q;
			end
			ST_POP: begin
				q_ctrl.pop = ~q_stat.empty;
			end
			ST_FETCH: begin
				grid_re    = 1'b1;
				grid_raddr = q_rdata;
			end
			ST_SCAN: begin
				grid_re     = (nb_cnt_q != NB_LAST) && nb_inbound;
				grid_we     = lower;
				q_ctrl.push = lower && !q_stat.full;
			end
			ST_READ: begin
				grid_re    = inside_q;
				grid_raddr = cell_addr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (grid_we)
			grid_mem[grid_waddr] <= grid_wdata;
		if (grid_re)
			grid_rdata_q <= grid_mem[grid_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_addr_q     <= '0;
			nb_cnt_q       <= '0;
			chk_vld_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + ADDR_W'(1);
					if (clr_addr_q == ADDR_W'(CELL_COUNT - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept) begin
						cell_addr_q <= in_addr;
						inside_q    <= in_inside;
						case (mode)
							MODE_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLEAR;
							end
							MODE_SEED: begin
								if (in_inside)
									state_q <= ST_SEED;
							end
							MODE_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_SEED: state_q <= ST_POP;
				ST_POP: begin
					state_q <= q_stat.empty ? ST_IDLE : ST_FETCH;
				end
				ST_FETCH: begin
					cur_addr_q <= q_rdata;
					state_q    <= ST_PARENT;
				end
				ST_PARENT: begin
					next_dist_q <= (grid_rdata_q >= DIST_CAP) ? DIST_CAP :
					               grid_rdata_q + DIST_W'(1);
					nb_cnt_q    <= '0;
					chk_vld_s1  <= 1'b0;
					state_q     <= ST_SCAN;
				end
				ST_SCAN: begin
					// Read neighbor k while checking and writing back neighbor k-1
					if (nb_cnt_q == NB_LAST) begin
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_POP;
					end else begin
						chk_vld_s1  <= nb_inbound;
						chk_addr_s1 <= nb_addr;
						nb_cnt_q    <= nb_cnt_q + 4'd1;
					end
				end
				ST_READ: state_q <= ST_REPLY;
				ST_REPLY: begin
					result_valid_q <= 1'b1;
					distance_q     <= reply_dist;
					known_q        <= (reply_dist != DIST_UNKNOWN);
					occupied_q     <= (reply_dist != DIST_UNKNOWN) &&
					                  (reply_dist < cfg.threshold);
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### verif/grid_wavefront_distance_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_wavefront_distance_map_tb
// Drives clear, seed and read transactions into the distance map and checks every
// read against a behavioral wavefront map kept in the bench, or a typed directed
// row's value. A directed table runs first at the reset register values, then
// random phases under several grid sizes and thresholds, with and without gaps.
// ----------------------------------------------------------------------------
module grid_wavefront_distance_map_tb;
	import gwd_pkg::*;

	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam logic [1:0] REG_UNMAPPED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned PEND_DEPTH  = 256;

	typedef struct packed {
		logic signed [7:0] dval;
		logic              known;
		logic              occ;
	} map_read_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [6:0] x;
		logic [6:0] y;
		logic       typed;
		map_read_t  want;
	} dir_row_t;

	typedef struct packed {
		logic [7:0] width;
		logic [7:0] height;
		logic [7:0] thresh;
		logic [7:0] idle_pct;
		logic [7:0] items;
	} phase_t;

	localparam map_read_t RD_UNKNOWN = '{8'hFF, 1'b0, 1'b0};
	localparam map_read_t RD_NONE    = '0;

	localparam int DIR_ROWS = 21;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{MODE_READ,   7'd0,   7'd0,   1'b1, RD_UNKNOWN},
		'{MODE_READ,   7'd127, 7'd127, 1'b1, RD_UNKNOWN},
		'{MODE_READ,   7'd63,  7'd63,  1'b1, RD_UNKNOWN},
		'{MODE_UNUSED, 7'd5,   7'd5,   1'b0, RD_NONE},
		'{MODE_SEED,   7'd127, 7'd0,   1'b0, RD_NONE},
		'{MODE_READ,   7'd127, 7'd0,   1'b1, RD_UNKNOWN},
		'{MODE_SEED,   7'd0,   7'd0,   1'b0, RD_NONE},
		'{MODE_READ,   7'd0,   7'd0,   1'b1, '{8'sd0,  1'b1, 1'b1}},
		'{MODE_READ,   7'd63,  7'd63,  1'b1, '{8'sd63, 1'b1, 1'b0}},
		'{MODE_READ,   7'd9,   7'd3,   1'b1, '{8'sd9,  1'b1, 1'b1}},
		'{MODE_READ,   7'd10,  7'd0,   1'b1, '{8'sd10, 1'b1, 1'b0}},
		'{MODE_READ,   7'd64,  7'd0,   1'b1, RD_UNKNOWN},
		'{MODE_SEED,   7'd63,  7'd63,  1'b0, RD_NONE},
		'{MODE_READ,   7'd32,  7'd32,  1'b0, RD_NONE},
		'{MODE_READ,   7'd40,  7'd10,  1'b0, RD_NONE},
		'{MODE_SEED,   7'd63,  7'd0,   1'b0, RD_NONE},
		'{MODE_READ,   7'd63,  7'd5,   1'b0, RD_NONE},
		'{MODE_READ,   7'd0,   7'd63,  1'b0, RD_NONE},
		'{MODE_CLEAR,  7'd127, 7'd127, 1'b0, RD_NONE},
		'{MODE_READ,   7'd63,  7'd5,   1'b1, RD_UNKNOWN},
		'{MODE_READ,   7'd0,   7'd0,   1'b1, RD_UNKNOWN}
	};

	localparam int PHASES = 6;
	localparam phase_t PHASE_TABLE [PHASES] = '{
		'{8'd8,   8'd8,   8'd0,   8'd0,  8'd14},
		'{8'd1,   8'd1,   8'd128, 8'd61, 8'd12},
		'{8'd255, 8'd2,   8'd255, 8'd30, 8'd14},
		'{8'd0,   8'd0,   8'd1,   8'd0,  8'd6},
		'{8'd5,   8'd128, 8'd3,   8'd61, 8'd18},
		'{8'd16,  8'd16,  8'd10,  8'd30, 8'd16}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                start;
	logic [1:0]          mode;
	logic [6:0]          cell_x;
	logic [6:0]          cell_y;
	logic                busy;
	logic                result_valid;
	logic signed [7:0]   distance;
	logic                known;
	logic                occupied;

	// Bench copy of the map and its registers
	logic [7:0]  dist_map [CELL_COUNT];
	int unsigned wave_q [CELL_COUNT];
	logic [7:0]  cfg_w;
	logic [7:0]  cfg_h;
	logic [7:0]  cfg_thr;

	// Expected read results, oldest at pend_rd
	map_read_t   pend_fifo [PEND_DEPTH];
	int unsigned pend_wr;
	int unsigned pend_rd;
	int unsigned idle_pct;
	int unsigned err_count;
	int unsigned cycle_count;
	int unsigned items_sent;
	int unsigned seeds_sent;
	int unsigned clears_sent;
	int unsigned reads_checked;

	grid_wavefront_distance_map u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.mode         (mode),
		.cell_x       (cell_x),
		.cell_y       (cell_y),
		.busy         (busy),
		.result_valid (result_valid),
		.distance     (distance),
		.known        (known),
		.occupied     (occupied)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned map_cols();
		return (cfg_w < MAX_WIDTH) ? int'(cfg_w) : MAX_WIDTH;
	endfunction

	function automatic int unsigned map_rows();
		return (cfg_h < MAX_HEIGHT) ? int'(cfg_h) : MAX_HEIGHT;
	endfunction

	// Breadth-first relaxation from one obstacle cell, neighbors column-major
	task automatic run_wavefront(input int unsigned sx, input int unsigned sy);
		int unsigned w, h, head, tail, idx, cx, cy, pd, nd, nidx;
		int          nx, ny, dx, dy;
		w = map_cols();
		h = map_rows();
		idx = sy * MAX_WIDTH + sx;
		dist_map[idx] = '0;
		wave_q[0] = idx;
		head = 0;
		tail = 1;
		while (head != tail) begin
			idx = wave_q[head % CELL_COUNT];
			cx = idx % MAX_WIDTH;
			cy = idx / MAX_WIDTH;
			pd = dist_map[idx];
			nd = (pd >= DIST_CAP) ? DIST_CAP : pd + 1;
			head++;
			for (dx = -1; dx <= 1; dx++) begin
				for (dy = -1; dy <= 1; dy++) begin
					nx = int'(cx) + dx;
					ny = int'(cy) + dy;
					if (nx < 0 || ny < 0 || nx >= int'(w) || ny >= int'(h))
						continue;
					nidx = ny * MAX_WIDTH + nx;
					if (dist_map[nidx] == DIST_UNKNOWN || dist_map[nidx] > nd) begin
						dist_map[nidx] = nd[7:0];
						if (tail - head < CELL_COUNT) begin
							wave_q[tail % CELL_COUNT] = nidx;
							tail++;
						end
					end
				end
			end
		end
	endtask

	task automatic predict_map_item(input logic [1:0] m, input logic [6:0] x,
			input logic [6:0] y, output bit has_read, output map_read_t r);
		bit         in_grid;
		logic [7:0] d;
		in_grid = (x < map_cols()) && (y < map_rows());
		has_read = 1'b0;
		r = RD_NONE;
		case (m)
			MODE_CLEAR: begin
				foreach (dist_map[i])
					dist_map[i] = DIST_UNKNOWN;
			end
			MODE_SEED: begin
				if (in_grid)
					run_wavefront(32'(x), 32'(y));
			end
			MODE_READ: begin
				d = in_grid ? dist_map[int'(y) * MAX_WIDTH + int'(x)] : DIST_UNKNOWN;
				has_read = 1'b1;
				r.dval = d;
				r.known = (d != DIST_UNKNOWN);
				r.occ = r.known && (d < cfg_thr);
			end
			default: ;
		endcase
	endtask

	// Issue one transaction, predict at the accepting edge, then maybe idle
	task automatic send_item(input logic [1:0] m, input logic [6:0] x, input logic [6:0] y,
			input logic typed, input map_read_t typed_want);
		bit        has_read;
		map_read_t pred;
		if (!start)
			start <= 1'b1;
		mode   <= m;
		cell_x <= x;
		cell_y <= y;
		do @(posedge clk); while (busy);
		predict_map_item(m, x, y, has_read, pred);
		if (has_read) begin
			pend_fifo[pend_wr % PEND_DEPTH] = typed ? typed_want : pred;
			pend_wr++;
		end
		items_sent++;
		if (m == MODE_SEED)
			seeds_sent++;
		if (m == MODE_CLEAR)
			clears_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic pick_random_item(output logic [1:0] m, output logic [6:0] x,
			output logic [6:0] y);
		int unsigned pick, c, r;
		pick = $urandom_range(99);
		c = map_cols();
		r = map_rows();
		if (pick < 4)
			m = MODE_CLEAR;
		else if (pick < 7)
			m = MODE_UNUSED;
		else if (pick < 32)
			m = MODE_SEED;
		else
			m = MODE_READ;
		if (c == 0 || r == 0 || $urandom_range(99) < 20) begin
			x = 7'($urandom_range(127));
			y = 7'($urandom_range(127));
		end else begin
			x = 7'($urandom_range(c - 1));
			y = 7'($urandom_range(r - 1));
		end
	endtask

	// Hold until every read is back and the block has dropped busy
	task automatic wait_map_idle();
		if (start)
			start <= 1'b0;
		while (pend_wr != pend_rd)
			@(posedge clk);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
		logic [31:0] noise;
		noise = $urandom();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= {noise[31:8], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_GRID_WIDTH:  cfg_w = value;
			REG_GRID_HEIGHT: cfg_h = value;
			REG_NEAR_THRESH: cfg_thr = value;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : read_check
		map_read_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (pend_wr == pend_rd) begin
				$display("%0t: read result with none pending: distance %0d known %0b occupied %0b",
					$time, distance, known, occupied);
				err_count++;
			end else begin
				want = pend_fifo[pend_rd % PEND_DEPTH];
				pend_rd++;
				reads_checked++;
				if (distance !== want.dval) begin
					$display("%0t: distance mismatch: expected %0d actual %0d",
						$time, want.dval, distance);
					err_count++;
				end
				if (known !== want.known) begin
					$display("%0t: known mismatch: expected %0b actual %0b",
						$time, want.known, known);
					err_count++;
				end
				if (occupied !== want.occ) begin
					$display("%0t: occupied mismatch: expected %0b actual %0b",
						$time, want.occ, occupied);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d reads pending", $time, pend_wr - pend_rd);
			$display("grid_wavefront_distance_map test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int          i, p;
		int unsigned done;
		logic [1:0]  m;
		logic [6:0]  x, y;
		phase_t      ph;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		start   <= 1'b0;
		mode    <= MODE_CLEAR;
		cell_x  <= '0;
		cell_y  <= '0;
		cfg_w   = 8'd64;
		cfg_h   = 8'd64;
		cfg_thr = 8'd10;
		foreach (dist_map[k])
			dist_map[k] = DIST_UNKNOWN;
		pend_wr = 0;
		pend_rd = 0;
		idle_pct = 0;
		err_count = 0;
		cycle_count = 0;
		items_sent = 0;
		seeds_sent = 0;
		clears_sent = 0;
		reads_checked = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TABLE[i].mode, DIR_TABLE[i].x, DIR_TABLE[i].y,
				DIR_TABLE[i].typed, DIR_TABLE[i].want);

		for (p = 0; p < PHASES; p++) begin
			ph = PHASE_TABLE[p];
			wait_map_idle();
			cfg_write(REG_GRID_WIDTH, ph.width);
			cfg_write(REG_GRID_HEIGHT, ph.height);
			cfg_write(REG_NEAR_THRESH, ph.thresh);
			// Unmapped register must not disturb the settings just written
			if (p == 0)
				cfg_write(REG_UNMAPPED, 8'h01);
			idle_pct = ph.idle_pct;
			done = 0;
			while (done < ph.items) begin
				pick_random_item(m, x, y);
				send_item(m, x, y, 1'b0, RD_NONE);
				if (!(m == MODE_UNUSED ||
						(m == MODE_SEED && !(x < map_cols() && y < map_rows()))))
					done++;
			end
		end

		wait_map_idle();
		repeat (20) @(posedge clk);
		if (pend_wr != pend_rd) begin
			$display("%0t: %0d reads never returned", $time, pend_wr - pend_rd);
			err_count += pend_wr - pend_rd;
		end
		$display("Sent %0d transactions (%0d seeds, %0d clears) over %0d register settings;",
			items_sent, seeds_sent, clears_sent, PHASES + 1);
		$display("checked %0d read results, %0d mismatches.", reads_checked, err_count);
		if (err_count == 0)
			$display("grid_wavefront_distance_map test passed");
		else
			$display("grid_wavefront_distance_map test failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/gwd_pkg.sv
rtl/core/gwd_cfg_regs.sv
rtl/core/gwd_queue.sv
rtl/core/gwd_engine.sv
rtl/core/grid_wavefront_distance_map.sv
verif/grid_wavefront_distance_map_tb.sv
